>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define SCPF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define SCPF_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> src/scpf_pkg.sv
// Types and constants of the strip calibration and peak finder.
package scpf_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_EOE    = 2'd2
    } t_opcode;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    // plane XR reads out with a shifted mirror
    localparam logic [1:0] PLANE_XR = 2'd2;

    localparam int VALUE_W     = 24;
    localparam int SAT_HI      = 8388607;
    localparam int SAT_LO      = -8388608;
    localparam int FLOOR_RESET = -100;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [1:0]          plane;
        logic [6:0]          channel;
        logic [15:0]         raw_value;
        logic [6:0]          strip_index;
        logic [15:0]         gain;
        logic signed [23:0]  strip_offset;
    } t_in_item;

    typedef struct packed {
        t_kind               kind;
        logic [1:0]          plane_res;
        logic [7:0]          strip;
        logic [15:0]         raw_out;
        logic signed [23:0]  value;
        logic                last;
    } t_out_item;

endpackage

>>> src/scpf_ifs.sv
// Request channel interfaces for the input and result streams.
interface scpf_in_if import scpf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface scpf_out_if import scpf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/scpf_ram.sv
// Simple dual-port RAM, one write port, one registered read port.
module scpf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/strip_calibrate_and_peak_find.sv
// Top level: strip remap, gain/offset calibration and per-plane peak tracking.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    t_in_item (opcode, plane, channel, raw, load fields)
//  o_out     out  valid/ready    t_out_item (kind, plane, strip, raw, value, last)
//  cfg       in   i_cfg_we       i_cfg_wdata = max_floor
//
// One request per cycle while neither a held stage nor the RAM clear holds i_in.ready low; a
// sample is registered in stage 1 at the edge that takes it (coefficient RAM read), then in
// stage 2 (multiply), then in the output register (subtract/saturate/compare).
// An end-of-event request holds stage 2 until it has sent PLANES reports, one per plane.
// After reset the coefficient RAM is swept to gain one / offset zero, one entry a
// cycle, over all PLANES*STRIPS entries (512 by default); i_in.ready stays low meanwhile.
// Stages advance only into a free slot, so a held result stalls just what is behind.
`include "assert_macros.svh"

module strip_calibrate_and_peak_find import scpf_pkg::*; #(
    parameter int STRIPS         = 128,
    parameter int PLANES         = 4,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    scpf_in_if.sink                  i_in,
    scpf_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic signed [VALUE_W-1:0] i_cfg_wdata
);

    localparam int DEPTH = PLANES * STRIPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIW   = $clog2(STRIPS);
    localparam int MW    = SIW + 1;
    localparam int NW    = $clog2(STRIPS + 1);
    localparam int PIW   = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int HALF  = STRIPS / 2;
    localparam int PRW   = 32 - GAIN_FRAC_BITS;
    localparam int DW    = ((PRW > VALUE_W) ? PRW : VALUE_W) + 2;
    localparam int RW    = 16 + VALUE_W;

    localparam logic [MW-1:0] M_HALF    = MW'(HALF);
    localparam logic [MW-1:0] M_LAST    = MW'(STRIPS - 1);
    localparam logic [MW-1:0] M_MIRROR  = MW'(STRIPS + HALF - 1);
    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [PIW-1:0] REP_LAST = PIW'(PLANES - 1);
    localparam logic [15:0]   GAIN_ONE  = 16'(1 << GAIN_FRAC_BITS);
    localparam logic signed [DW-1:0] D_HI = DW'(SAT_HI);
    localparam logic signed [DW-1:0] D_LO = DW'(SAT_LO);
    localparam logic signed [VALUE_W-1:0] V_HI = VALUE_W'(SAT_HI);
    localparam logic signed [VALUE_W-1:0] V_LO = VALUE_W'(SAT_LO);
    localparam logic signed [VALUE_W-1:0] V_FLOOR = VALUE_W'(FLOOR_RESET);

    t_in_item in_item;
    logic     accept;
    logic     is_sample, is_load, is_eoe;
    logic [MW-1:0] chan_m, map_m;
    logic [SIW-1:0] map_s;
    logic [AW-1:0]  rd_addr, ld_addr;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [RW-1:0]  ram_wdata, ram_rdata;

    logic           r_clr_busy;
    logic [AW-1:0]  r_clr_addr;
    logic signed [VALUE_W-1:0] r_floor;

    // stage 1: item plus RAM read data
    logic           r_s1_v, r_s1_eoe;
    logic [1:0]     r_s1_plane;
    logic [NW-1:0]  r_s1_n;
    logic [15:0]    r_s1_raw;
    // stage 2: scaled product
    logic           r_s2_v, r_s2_eoe;
    logic [1:0]     r_s2_plane;
    logic [NW-1:0]  r_s2_n;
    logic [15:0]    r_s2_raw;
    logic [PRW-1:0] r_s2_prod;
    logic signed [VALUE_W-1:0] r_s2_offs;
    // output register
    logic           r_out_v;
    t_out_item      r_out;

    logic signed [VALUE_W-1:0] r_max [PLANES];
    logic [NW-1:0]             r_peak [PLANES];
    logic [PIW-1:0]            r_rep_cnt;

    logic signed [VALUE_W-1:0] n_max [PLANES];
    logic [NW-1:0]             n_peak [PLANES];
    logic [PIW-1:0]            n_rep_cnt;
    t_out_item                 n_out;

    logic [31:0]    prod;
    logic signed [DW-1:0] diff;
    logic signed [VALUE_W-1:0] sat_val;
    logic [PIW-1:0] s2_pidx;
    logic           win, rep_last;
    logic           out_free, s2_emit, s2_go, s2_free, s1_go, s1_free, rep_done;

    assign in_item = i_in.payload;
    assign accept  = i_in.valid && i_in.ready;

    assign is_sample = (in_item.opcode == OP_SAMPLE) && (32'(in_item.plane) < PLANES)
                       && (32'(in_item.channel) < STRIPS);
    assign is_load   = (in_item.opcode == OP_LOAD) && (32'(in_item.plane) < PLANES)
                       && (32'(in_item.strip_index) < STRIPS);
    assign is_eoe    = (in_item.opcode == OP_EOE);

    // channel to strip: mirrored halves, XR mirrored the other way round
    assign chan_m = MW'(in_item.channel);
    always_comb begin
        if (in_item.plane == PLANE_XR) begin
            map_m = (chan_m >= M_HALF) ? chan_m - M_HALF : M_LAST - chan_m;
        end else begin
            map_m = (chan_m < M_HALF) ? chan_m : M_MIRROR - chan_m;
        end
    end
    assign map_s   = SIW'(map_m);
    assign rd_addr = AW'(32'(in_item.plane) * STRIPS + 32'(map_s));
    assign ld_addr = AW'(32'(in_item.plane) * STRIPS + 32'(in_item.strip_index));

    assign ram_we    = r_clr_busy || (accept && is_load);
    assign ram_waddr = r_clr_busy ? r_clr_addr : ld_addr;
    assign ram_wdata = r_clr_busy ? {GAIN_ONE, {VALUE_W{1'b0}}}
                                  : {in_item.gain, in_item.strip_offset};

    scpf_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // flow control
    assign rep_last = (r_rep_cnt == REP_LAST);
    assign out_free = !r_out_v || o_out.ready;
    assign s2_emit  = r_s2_v && out_free;
    assign s2_go    = s2_emit && (!r_s2_eoe || rep_last);
    assign rep_done = s2_emit && r_s2_eoe && rep_last;
    assign s2_free  = !r_s2_v || s2_go;
    assign s1_go    = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || s1_go;

    assign i_in.ready = !r_clr_busy && s1_free;

    // stage 1 -> 2 multiply
    assign prod = {16'b0, r_s1_raw} * {16'b0, ram_rdata[RW-1:VALUE_W]};

    // stage 2 subtract, saturate, compare
    assign diff = $signed({{(DW-PRW){1'b0}}, r_s2_prod})
                  - $signed({{(DW-VALUE_W){r_s2_offs[VALUE_W-1]}}, r_s2_offs});
    always_comb begin
        if (diff > D_HI) begin
            sat_val = V_HI;
        end else if (diff < D_LO) begin
            sat_val = V_LO;
        end else begin
            sat_val = diff[VALUE_W-1:0];
        end
    end

    assign s2_pidx = PIW'(r_s2_plane);
    // ties keep the lower strip once a strip is held
    assign win = (sat_val > r_max[s2_pidx])
                 || ((sat_val == r_max[s2_pidx]) && (r_peak[s2_pidx] != '0)
                     && (r_s2_n < r_peak[s2_pidx]));

    always_comb begin
        n_max     = r_max;
        n_peak    = r_peak;
        n_rep_cnt = r_rep_cnt;
        if (s2_emit && r_s2_eoe) begin
            n_rep_cnt = rep_last ? '0 : r_rep_cnt + 1'b1;
            if (rep_last) begin
                for (int p = 0; p < PLANES; p++) begin
                    n_max[p]  = r_floor;
                    n_peak[p] = '0;
                end
            end
        end else if (s2_emit && win) begin
            n_max[s2_pidx]  = sat_val;
            n_peak[s2_pidx] = r_s2_n;
        end
    end

    always_comb begin
        if (r_s2_eoe) begin
            n_out.kind      = KIND_REPORT;
            n_out.plane_res = 2'(r_rep_cnt);
            n_out.strip     = 8'(r_peak[r_rep_cnt]);
            n_out.raw_out   = '0;
            n_out.value     = r_max[r_rep_cnt];
            n_out.last      = rep_last;
        end else begin
            n_out.kind      = KIND_SAMPLE;
            n_out.plane_res = r_s2_plane;
            n_out.strip     = 8'(r_s2_n);
            n_out.raw_out   = r_s2_raw;
            n_out.value     = sat_val;
            n_out.last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_floor    <= V_FLOOR;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_rep_cnt  <= '0;
            for (int p = 0; p < PLANES; p++) begin
                r_max[p]  <= V_FLOOR;
                r_peak[p] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                r_floor <= i_cfg_wdata;
            end
            if (s1_free) begin
                r_s1_v <= accept && (is_sample || is_eoe);
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (out_free) begin
                r_out_v <= s2_emit;
            end
            r_rep_cnt <= n_rep_cnt;
            r_max     <= n_max;
            r_peak    <= n_peak;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_eoe   <= is_eoe;
            r_s1_plane <= in_item.plane;
            r_s1_n     <= NW'(map_s) + 1'b1;
            r_s1_raw   <= in_item.raw_value;
        end
        if (s1_go) begin
            r_s2_eoe   <= r_s1_eoe;
            r_s2_plane <= r_s1_plane;
            r_s2_n     <= r_s1_n;
            r_s2_raw   <= r_s1_raw;
            r_s2_prod  <= PRW'(prod >> GAIN_FRAC_BITS);
            r_s2_offs  <= ram_rdata[VALUE_W-1:0];
        end
        if (s2_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

    `SCPF_ASSERT_ALWAYS(a_no_take_in_clear, i_clk, r_clr_busy |-> !i_in.ready, "request taken during RAM clear")
    `SCPF_ASSERT_RUN(a_rep_cnt_owner, i_clk, i_rst_n, (r_rep_cnt != '0) |-> (r_s2_v && r_s2_eoe), "report count running without end of event")
    `SCPF_ASSERT_RUN(a_clear_after_rep, i_clk, i_rst_n, rep_done |=> (r_peak[0] == '0), "trackers not cleared after reports")
    `SCPF_ASSERT_RUN(a_only_rep_not_last, i_clk, i_rst_n, (o_out.valid && !o_out.payload.last) |-> (o_out.payload.kind == KIND_REPORT), "sample result without last")

endmodule

>>> tb/strip_calibrate_and_peak_find_test.sv
`timescale 1ns / 1ps
// Self-checking test of the strip calibrate and peak finder: directed table, then random phases.
module strip_calibrate_and_peak_find_test;
    import scpf_pkg::*;

    localparam int N_STRIPS  = 128;
    localparam int N_PLANES  = 4;
    localparam int FRAC_BITS = 12;
    localparam int HALF      = N_STRIPS / 2;
    localparam int GAIN_ONE  = 1 << FRAC_BITS;
    localparam int DRAIN_CYC = 12;    // pipeline depth plus one report burst, with slack
    localparam int HOLD_CYC  = 300;
    localparam int PHASE_LEN = 90;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_in_item    req;
        bit          typed;    // expected result given in the row
        logic [7:0]  strip;
        int          value;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic signed [VALUE_W-1:0] cfg_wdata;

    scpf_in_if  in_if ();
    scpf_out_if out_if ();

    strip_calibrate_and_peak_find dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // calibration model state
    logic [15:0]        gain_tbl [N_PLANES*N_STRIPS];
    logic signed [23:0] offs_tbl [N_PLANES*N_STRIPS];
    int                 peak_val [N_PLANES];
    int                 peak_strip [N_PLANES];
    int                 floor_val;

    t_out_item pending_results[$];

    bit calm;        // no idling on either side
    bit hold_req;
    int hold_left;

    int n_req, n_checked, n_samples, n_reports, n_err, n_floor;

    always #6 i_clk = ~i_clk;

    initial begin
        #3_600_000;
        $display("timeout: %0d results still pending", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_err(string msg);
        n_err++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_err($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    function automatic int unsigned strip_of(logic [1:0] plane, logic [6:0] chan);
        int unsigned c;
        c = chan;
        if (plane == PLANE_XR)
            return (c >= HALF) ? c - HALF : N_STRIPS - 1 - c;
        return (c < HALF) ? c : N_STRIPS + HALF - 1 - c;
    endfunction

    function automatic void clear_peaks();
        for (int p = 0; p < N_PLANES; p++) begin
            peak_val[p]   = floor_val;
            peak_strip[p] = 0;
        end
    endfunction

    // updates the model for one accepted request; queues its results if keep is set
    function automatic void calib_predict(t_in_item r, bit keep);
        int unsigned s, idx;
        logic [31:0] prod;
        longint v;
        int val, p;
        t_out_item o;
        p = r.plane;
        case (r.opcode)
            OP_SAMPLE: begin
                s    = strip_of(r.plane, r.channel);
                idx  = p * N_STRIPS + s;
                prod = r.raw_value * gain_tbl[idx];
                v    = longint'(prod >> FRAC_BITS) - longint'(offs_tbl[idx]);
                if (v > SAT_HI) v = SAT_HI;
                if (v < SAT_LO) v = SAT_LO;
                val = int'(v);
                if (val > peak_val[p] ||
                    (val == peak_val[p] && peak_strip[p] != 0 && s + 1 < peak_strip[p])) begin
                    peak_val[p]   = val;
                    peak_strip[p] = s + 1;
                end
                o.kind      = KIND_SAMPLE;
                o.plane_res = r.plane;
                o.strip     = s + 1;
                o.raw_out   = r.raw_value;
                o.value     = val;
                o.last      = 1'b1;
                if (keep) pending_results.push_back(o);
            end
            OP_LOAD: begin
                idx = p * N_STRIPS + r.strip_index;
                gain_tbl[idx] = r.gain;
                offs_tbl[idx] = r.strip_offset;
            end
            OP_EOE: begin
                for (int q = 0; q < N_PLANES; q++) begin
                    o.kind      = KIND_REPORT;
                    o.plane_res = q;
                    o.strip     = peak_strip[q];
                    o.raw_out   = '0;
                    o.value     = peak_val[q];
                    o.last      = (q == N_PLANES - 1);
                    if (keep) pending_results.push_back(o);
                end
                clear_peaks();
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item mk_req(logic [1:0] op, logic [1:0] plane, logic [6:0] chan,
                                        logic [15:0] raw, logic [6:0] sidx, logic [15:0] gain,
                                        int offs);
        t_in_item r;
        r.opcode       = op;
        r.plane        = plane;
        r.channel      = chan;
        r.raw_value    = raw;
        r.strip_index  = sidx;
        r.gain         = gain;
        r.strip_offset = offs;
        return r;
    endfunction

    function automatic t_in_item random_req();
        t_in_item r;
        int roll;
        r.plane        = $urandom;
        r.channel      = $urandom;
        r.raw_value    = $urandom;
        r.strip_index  = $urandom;
        r.gain         = $urandom;
        r.strip_offset = $urandom;
        roll = $urandom_range(99);
        if (roll < 68) begin
            r.opcode = OP_SAMPLE;
            // coarse raw values make ties on the peak likely
            if ($urandom_range(3) == 0) r.raw_value = $urandom_range(7) * 100;
        end else if (roll < 83) begin
            r.opcode = OP_LOAD;
            case ($urandom_range(3))
                0: ;
                1, 2: begin
                    r.gain         = GAIN_ONE - 512 + $urandom_range(1024);
                    r.strip_offset = int'($urandom_range(4000)) - 2000;
                end
                default: begin
                    r.gain         = GAIN_ONE;
                    r.strip_offset = 0;
                end
            endcase
        end else if (roll < 93) begin
            r.opcode = OP_EOE;
        end else begin
            r.opcode = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic send_req(t_in_item r, bit typed = 0, logic [7:0] strip = 0, int value = 0);
        t_out_item o;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= r;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        n_req++;
        calib_predict(r, !typed);
        if (typed) begin
            if (r.opcode == OP_SAMPLE) begin
                o.kind      = KIND_SAMPLE;
                o.plane_res = r.plane;
                o.strip     = strip;
                o.raw_out   = r.raw_value;
                o.value     = value;
                o.last      = 1'b1;
                pending_results.push_back(o);
            end else if (r.opcode == OP_EOE) begin
                for (int q = 0; q < N_PLANES; q++) begin
                    o.kind      = KIND_REPORT;
                    o.plane_res = q;
                    o.strip     = strip;
                    o.raw_out   = '0;
                    o.value     = value;
                    o.last      = (q == N_PLANES - 1);
                    pending_results.push_back(o);
                end
            end
        end
    endtask

    // drop valid and wait until every expected result is back and the pipe is empty
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_floor(int f);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= f;
        floor_val = f;
        n_floor++;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYC;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge i_clk) begin
        t_out_item got, want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got = out_if.payload;
            if (pending_results.size() == 0) begin
                report_err($sformatf("result with nothing expected: %p", got));
            end else begin
                want = pending_results.pop_front();
                check_field("kind", got.kind, want.kind);
                check_field("plane_res", got.plane_res, want.plane_res);
                check_field("strip", got.strip, want.strip);
                check_field("raw_out", got.raw_out, want.raw_out);
                check_field("value", got.value, want.value);
                check_field("last", got.last, want.last);
                n_checked++;
                if (want.kind == KIND_SAMPLE) n_samples++;
                else n_reports++;
            end
        end
    end

    initial begin
        t_row rows[$];
        int floors[4];

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        calm          = 0;
        hold_req      = 0;
        hold_left     = 0;
        for (int i = 0; i < N_PLANES * N_STRIPS; i++) begin
            gain_tbl[i] = GAIN_ONE;
            offs_tbl[i] = '0;
        end
        floor_val = FLOOR_RESET;
        clear_peaks();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing found yet: every plane reports the reset floor
        rows.push_back('{mk_req(OP_EOE, 0, 0, 0, 0, 0, 0), 1, 8'd0, FLOOR_RESET});
        // mapping corners, gain one and offset zero
        rows.push_back('{mk_req(OP_SAMPLE, 0, 0, 0, 0, 0, 0), 1, 8'd1, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 0, 127, 16'hFFFF, 0, 0, 0), 1, 8'd65, 65535});
        rows.push_back('{mk_req(OP_SAMPLE, 2, 64, 100, 0, 0, 0), 1, 8'd1, 100});
        rows.push_back('{mk_req(OP_SAMPLE, 2, 0, 5, 0, 0, 0), 1, 8'd128, 5});
        rows.push_back('{mk_req(OP_SAMPLE, 2, 63, 7, 0, 0, 0), 1, 8'd65, 7});
        rows.push_back('{mk_req(OP_SAMPLE, 1, 63, 9, 0, 0, 0), 1, 8'd64, 9});
        // YR below the XL peak must still win on its own plane
        rows.push_back('{mk_req(OP_SAMPLE, 3, 64, 11, 0, 0, 0), 1, 8'd128, 11});
        // saturation high: max gain, most negative offset
        rows.push_back('{mk_req(OP_LOAD, 0, 0, 0, 5, 16'hFFFF, SAT_LO), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 0, 5, 16'hFFFF, 0, 0, 0), 1, 8'd6, SAT_HI});
        // zero gain, largest offset
        rows.push_back('{mk_req(OP_LOAD, 1, 0, 0, 10, 0, SAT_HI), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 1, 10, 1234, 0, 0, 0), 1, 8'd11, SAT_LO + 1});
        rows.push_back('{mk_req(OP_LOAD, 3, 0, 0, 127, 16'd8192, 0), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 3, 64, 16'hFFFF, 0, 0, 0), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_UNUSED, 2, 7, 77, 7, 7, 7), 0, 8'd0, 0});
        // equal values: lower strip takes the peak
        rows.push_back('{mk_req(OP_SAMPLE, 1, 30, 500, 0, 0, 0), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 1, 25, 500, 0, 0, 0), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 1, 40, 500, 0, 0, 0), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_EOE, 3, 0, 0, 0, 0, 0), 0, 8'd0, 0});
        // value equal to the floor with no strip held does not win
        rows.push_back('{mk_req(OP_LOAD, 2, 0, 0, 3, GAIN_ONE, 100), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_SAMPLE, 2, 67, 0, 0, 0, 0), 1, 8'd4, FLOOR_RESET});
        rows.push_back('{mk_req(OP_SAMPLE, 0, 0, 16'hFFFF, 0, 0, 0), 0, 8'd0, 0});
        rows.push_back('{mk_req(OP_EOE, 1, 0, 0, 0, 0, 0), 0, 8'd0, 0});

        foreach (rows[i])
            send_req(rows[i].req, rows[i].typed, rows[i].strip, rows[i].value);
        settle();

        floors[0] = SAT_HI;
        floors[1] = SAT_LO;
        floors[2] = int'($urandom_range(60000)) - 30000;
        floors[3] = FLOOR_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            write_floor(floors[ph]);
            calm = (ph == 1);
            if (ph == 2) hold_req = 1;
            // end of event first so the new floor takes effect
            send_req(mk_req(OP_EOE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
            repeat (PHASE_LEN - 1) send_req(random_req());
            settle();
        end
        calm = 0;

        $display("%0d requests sent, %0d results checked (%0d samples, %0d plane reports)",
                 n_req, n_checked, n_samples, n_reports);
        $display("%0d floor settings used, %0d mismatches", n_floor, n_err);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/scpf_pkg.sv
src/scpf_ifs.sv
src/scpf_ram.sv
src/strip_calibrate_and_peak_find.sv
tb/strip_calibrate_and_peak_find_test.sv
